@@ hdl/kfhe_pkg.sv @@
package kfhe_pkg;

	localparam int NUM_CURVES_DEF = 64;
	localparam int MAX_KEYS_DEF   = 256;

	// item modes
	localparam logic [2:0] MODE_HDR   = 3'd0;
	localparam logic [2:0] MODE_KEY   = 3'd1;
	localparam logic [2:0] MODE_EVAL  = 3'd2;
	localparam logic [2:0] MODE_START = 3'd3;
	localparam logic [2:0] MODE_END   = 3'd4;

	// curve kinds
	localparam logic [2:0] KIND_ZERO   = 3'd0;
	localparam logic [2:0] KIND_STATIC = 3'd1;
	localparam logic [2:0] KIND_SLOPE0 = 3'd2;
	localparam logic [2:0] KIND_HERM   = 3'd3;

	// key address select
	localparam logic [2:0] ADR_MID  = 3'd0;
	localparam logic [2:0] ADR_K    = 3'd1;
	localparam logic [2:0] ADR_KM1  = 3'd2;
	localparam logic [2:0] ADR_ZERO = 3'd3;
	localparam logic [2:0] ADR_LAST = 3'd4;

	// result select
	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_KEY  = 2'd1;
	localparam logic [1:0] RES_ACC  = 2'd2;

	// multiply steps, run in this order
	localparam logic [2:0] OP_TT  = 3'd0;
	localparam logic [2:0] OP_H   = 3'd1;
	localparam logic [2:0] OP_DH  = 3'd2;
	localparam logic [2:0] OP_AM1 = 3'd3;
	localparam logic [2:0] OP_AM2 = 3'd4;
	localparam logic [2:0] OP_BB  = 3'd5;
	localparam logic [2:0] OP_DHI = 3'd6;
	localparam logic [2:0] OP_DLO = 3'd7;

	localparam logic [4:0] DIV_LAST = 5'd29;

	typedef struct packed {
		logic       take;
		logic       hdr_rd;
		logic       key_rd;
		logic [2:0] addr_sel;
		logic       srch_init;
		logic       srch_step;
		logic       scan_step;
		logic       keep_k;
		logic       div_init;
		logic       div_step;
		logic       mul_go;
		logic       wb_go;
		logic [2:0] mop;
		logic       out_load;
		logic [1:0] res_sel;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       curve_ok;
		logic [2:0] kind;
		logic       len_zero;
		logic       k_zero;
		logic       scan_done;
		logic       mid_gt;
		logic       hit;
		logic       exact;
		logic       interp_ok;
		logic       div_done;
		logic       out_free;
	} sts_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
		else if (v < -64'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

@@ hdl/keyframe_hermite_curve_eval_unit.sv @@
// Keyframe curve store and evaluator (cubic Hermite / smoothstep, Q16.16).
// Input channel (in_valid/in_ready): one word per item. Header and key writes
// give no result. Evaluate, start and end queries give one result word on
// the output channel (out_valid/out_ready). Start/end queries and static
// curves answer without a search. An evaluate query on a spline curve uses
// a binary search with one key-memory read per step, a forward scan, a
// 30-step restoring divider for the segment fraction, and one shared 34x34
// multiplier used three times (slope-zero kind) or eight times (Hermite kind).
// One item is processed at a time; the next is accepted as soon as the
// result sits in the output register, even if the receiver has not taken it.
// If the receiver stalls, a finished query waits until the register frees.
// Reset clears floor_frame and the curve headers (all curves kind zero,
// count zero). Key memory is not cleared; keys must be written before use.
// Config channel (cfg_valid/cfg_ready, cfg_data = floor_frame) is always ready.
module keyframe_hermite_curve_eval_unit #(
	parameter int NUM_CURVES = kfhe_pkg::NUM_CURVES_DEF,
	parameter int MAX_KEYS   = kfhe_pkg::MAX_KEYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [5:0]         curve_index,
	input  logic [7:0]         key_slot,
	input  logic [2:0]         curve_kind,
	input  logic [8:0]         key_count,
	input  logic [15:0]        key_frame,
	input  logic signed [31:0] key_value,
	input  logic signed [31:0] key_tangent,
	input  logic [31:0]        query_frame,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value
);

	kfhe_pkg::cmd_t cmd;
	kfhe_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	kfhe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.s        (sts),
		.c        (cmd)
	);

	kfhe_dp #(.NUM_CURVES(NUM_CURVES), .MAX_KEYS(MAX_KEYS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.c            (cmd),
		.s            (sts),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.curve_index  (curve_index),
		.key_slot     (key_slot),
		.curve_kind   (curve_kind),
		.key_count    (key_count),
		.key_frame    (key_frame),
		.key_value    (key_value),
		.key_tangent  (key_tangent),
		.query_frame  (query_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value)
	);

endmodule

@@ hdl/kfhe_ram.sv @@
module kfhe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

@@ hdl/kfhe_dp.sv @@
module kfhe_dp #(
	parameter int NUM_CURVES = kfhe_pkg::NUM_CURVES_DEF,
	parameter int MAX_KEYS   = kfhe_pkg::MAX_KEYS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kfhe_pkg::cmd_t      c,
	output kfhe_pkg::sts_t      s,
	input  logic                cfg_valid,
	input  logic                cfg_data,
	input  logic [2:0]          mode,
	input  logic [5:0]          curve_index,
	input  logic [7:0]          key_slot,
	input  logic [2:0]          curve_kind,
	input  logic [8:0]          key_count,
	input  logic [15:0]         key_frame,
	input  logic signed [31:0]  key_value,
	input  logic signed [31:0]  key_tangent,
	input  logic [31:0]         query_frame,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  result_value
);

	localparam int DEPTH  = NUM_CURVES * MAX_KEYS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(MAX_KEYS + 1);
	localparam int CRV_W  = NUM_CURVES > 1 ? $clog2(NUM_CURVES) : 1;
	localparam int HDR_W  = 3 + CNT_W;

	logic              floor_q;
	logic [2:0]        mode_q;
	logic              curve_ok_q;
	logic [31:0]       qf_q;
	logic [ADDR_W-1:0] base_q;
	logic [CRV_W-1:0]  crv_q;
	logic [NUM_CURVES-1:0] hdr_vld_q;
	logic              hv_q;

	logic              curve_ok_in;
	logic              key_ok_in;
	logic [CNT_W-1:0]  cnt_in;
	logic [ADDR_W-1:0] base_in;

	logic [HDR_W-1:0]  hdr_rdata;
	logic [2:0]        kind;
	logic [CNT_W-1:0]  n;

	logic [79:0]       key_rdata;
	logic [15:0]       rd_frame;
	logic signed [31:0] rd_value;
	logic signed [31:0] rd_tangent;
	logic [ADDR_W-1:0] key_raddr;
	logic [CNT_W-1:0]  idx;

	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  half;

	logic [15:0]       kf_q;
	logic signed [31:0] p2_q, m2_q, p1_q, m1_q;
	logic [31:0]       df_q;
	logic [31:0]       df_c;
	logic [15:0]       span_q;
	logic [15:0]       rem_q;
	logic [29:0]       num_q;
	logic [4:0]        div_cnt_q;
	logic [16:0]       r2;
	logic              ge;

	logic [29:0]       t2_q;
	logic [30:0]       h_q;
	logic signed [63:0] acc_q;
	logic signed [33:0] a_q;
	logic signed [33:0] bb_q;
	logic signed [63:0] v_q;
	logic signed [67:0] prod_s1;
	logic signed [33:0] mul_a, mul_b;
	logic signed [33:0] t_s, tm1_s;
	logic [31:0]       h_fac;
	logic signed [67:0] sum_am;

	logic              out_valid_q;
	logic signed [31:0] result_q;

	assign curve_ok_in = 32'(curve_index) < 32'(NUM_CURVES);
	assign key_ok_in   = 32'(key_slot) < 32'(MAX_KEYS);
	assign cnt_in      = (32'(key_count) > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count);
	assign base_in     = ADDR_W'(32'(curve_index) * 32'(MAX_KEYS));

	kfhe_ram #(.WIDTH(HDR_W), .DEPTH(NUM_CURVES)) u_hdr_ram (
		.clk   (clk),
		.we    (c.take && mode == kfhe_pkg::MODE_HDR && curve_ok_in),
		.waddr (CRV_W'(curve_index)),
		.wdata ({curve_kind, cnt_in}),
		.re    (c.hdr_rd),
		.raddr (crv_q),
		.rdata (hdr_rdata)
	);

	kfhe_ram #(.WIDTH(80), .DEPTH(DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (c.take && mode == kfhe_pkg::MODE_KEY && curve_ok_in && key_ok_in),
		.waddr (ADDR_W'(base_in + ADDR_W'(key_slot))),
		.wdata ({key_frame, key_value, key_tangent}),
		.re    (c.key_rd),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	assign kind       = hv_q ? hdr_rdata[HDR_W-1 -: 3] : kfhe_pkg::KIND_ZERO;
	assign n          = hv_q ? hdr_rdata[CNT_W-1:0] : '0;
	assign rd_frame   = key_rdata[79:64];
	assign rd_value   = key_rdata[63:32];
	assign rd_tangent = key_rdata[31:0];
	assign half       = len_q >> 1;

	always_comb begin
		case (c.addr_sel)
			kfhe_pkg::ADR_MID:  idx = CNT_W'(k_q + half);
			kfhe_pkg::ADR_K:    idx = k_q;
			kfhe_pkg::ADR_KM1:  idx = CNT_W'(k_q - 1'b1);
			kfhe_pkg::ADR_LAST: idx = (n == '0) ? '0 : CNT_W'(n - 1'b1);
			default:            idx = '0;
		endcase
		key_raddr = ADDR_W'(base_q + ADDR_W'(idx));
	end

	assign df_c = qf_q - {rd_frame, 16'h0000};

	// one restoring division bit per cycle
	assign r2 = {rem_q, num_q[29]};
	assign ge = r2 >= {1'b0, span_q};

	assign t_s   = $signed({4'b0000, num_q});
	assign tm1_s = t_s - 34'sd1073741824;
	assign h_fac = 32'hC000_0000 - {1'b0, num_q, 1'b0};

	always_comb begin
		case (c.mop)
			kfhe_pkg::OP_TT:  begin mul_a = t_s; mul_b = t_s; end
			kfhe_pkg::OP_H:   begin mul_a = $signed({2'b00, h_fac}); mul_b = $signed({4'b0000, t2_q}); end
			kfhe_pkg::OP_DH:  begin
				mul_a = $signed({{2{p2_q[31]}}, p2_q}) - $signed({{2{p1_q[31]}}, p1_q});
				mul_b = $signed({3'b000, h_q});
			end
			kfhe_pkg::OP_AM1: begin mul_a = tm1_s; mul_b = $signed({{2{m1_q[31]}}, m1_q}); end
			kfhe_pkg::OP_AM2: begin mul_a = t_s; mul_b = $signed({{2{m2_q[31]}}, m2_q}); end
			kfhe_pkg::OP_BB:  begin mul_a = a_q; mul_b = tm1_s; end
			kfhe_pkg::OP_DHI: begin mul_a = bb_q; mul_b = $signed({18'b0, df_q[31:16]}); end
			default:          begin mul_a = bb_q; mul_b = $signed({18'b0, df_q[15:0]}); end
		endcase
	end

	assign sum_am = 68'(acc_q) + prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q     <= 1'b0;
			hdr_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) floor_q <= cfg_data;
			if (c.take && mode == kfhe_pkg::MODE_HDR && curve_ok_in)
				hdr_vld_q[CRV_W'(curve_index)] <= 1'b1;
			if (c.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (c.take) begin
			mode_q     <= mode;
			curve_ok_q <= curve_ok_in;
			base_q     <= base_in;
			crv_q      <= CRV_W'(curve_index);
			qf_q       <= floor_q ? {query_frame[31:16], 16'h0000} : query_frame;
		end
		if (c.hdr_rd) hv_q <= hdr_vld_q[crv_q];
		if (c.srch_init) begin
			k_q   <= '0;
			len_q <= n;
		end else if (c.srch_step) begin
			if (rd_frame > qf_q[31:16]) begin
				len_q <= half;
			end else begin
				k_q   <= CNT_W'(k_q + half + 1'b1);
				len_q <= CNT_W'(len_q - half - 1'b1);
			end
		end else if (c.scan_step) begin
			k_q <= CNT_W'(k_q + 1'b1);
		end
		if (c.keep_k) begin
			kf_q <= rd_frame;
			p2_q <= rd_value;
			m2_q <= rd_tangent;
		end
		if (c.div_init) begin
			df_q      <= df_c;
			span_q    <= kf_q - rd_frame;
			p1_q      <= rd_value;
			m1_q      <= rd_tangent;
			rem_q     <= df_c[31:16];
			num_q     <= {df_c[15:0], 14'h0000};
			div_cnt_q <= '0;
		end else if (c.div_step) begin
			rem_q     <= ge ? 16'(r2 - {1'b0, span_q}) : r2[15:0];
			num_q     <= {num_q[28:0], ge};
			div_cnt_q <= div_cnt_q + 5'd1;
		end
		if (c.mul_go) prod_s1 <= mul_a * mul_b;
		if (c.wb_go) begin
			case (c.mop)
				kfhe_pkg::OP_TT:  t2_q <= prod_s1[59:30];
				kfhe_pkg::OP_H:   h_q <= prod_s1[60:30];
				kfhe_pkg::OP_DH:  v_q <= 64'(p1_q) + 64'(prod_s1 >>> 30);
				kfhe_pkg::OP_AM1: acc_q <= 64'(prod_s1);
				kfhe_pkg::OP_AM2: a_q <= 34'(sum_am >>> 30);
				kfhe_pkg::OP_BB:  bb_q <= 34'(prod_s1 >>> 30);
				kfhe_pkg::OP_DHI: v_q <= v_q + 64'(prod_s1);
				default:          v_q <= v_q + 64'(prod_s1 >>> 16);
			endcase
		end
		if (c.out_load) begin
			case (c.res_sel)
				kfhe_pkg::RES_KEY: result_q <= rd_value;
				kfhe_pkg::RES_ACC: result_q <= $signed(kfhe_pkg::sat32(v_q));
				default:           result_q <= '0;
			endcase
		end
	end

	assign s.mode      = mode_q;
	assign s.curve_ok  = curve_ok_q;
	assign s.kind      = kind;
	assign s.len_zero  = len_q == '0;
	assign s.k_zero    = k_q == '0;
	assign s.scan_done = k_q >= n;
	assign s.mid_gt    = rd_frame > qf_q[31:16];
	assign s.hit       = {rd_frame, 16'h0000} >= qf_q;
	assign s.exact     = {rd_frame, 16'h0000} == qf_q;
	assign s.interp_ok = (qf_q >= {rd_frame, 16'h0000}) && (kf_q > rd_frame);
	assign s.div_done  = div_cnt_q == kfhe_pkg::DIV_LAST;
	assign s.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign result_value = result_q;

endmodule

@@ hdl/kfhe_ctrl.sv @@
module kfhe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  kfhe_pkg::sts_t s,
	output kfhe_pkg::cmd_t c
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_HDR    = 4'd2;
	localparam logic [3:0] S_SRCH   = 4'd3;
	localparam logic [3:0] S_SRCH_W = 4'd4;
	localparam logic [3:0] S_SCAN   = 4'd5;
	localparam logic [3:0] S_SCAN_W = 4'd6;
	localparam logic [3:0] S_PREV_W = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_MUL    = 4'd9;
	localparam logic [3:0] S_WB     = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;

	logic [3:0] state_q, state_n;
	logic [2:0] mop_q, mop_n;
	logic [1:0] res_q, res_n;
	logic       spline;
	logic       query;

	assign spline = s.kind == kfhe_pkg::KIND_SLOPE0 || s.kind == kfhe_pkg::KIND_HERM;
	assign query  = s.mode == kfhe_pkg::MODE_EVAL || s.mode == kfhe_pkg::MODE_START
		|| s.mode == kfhe_pkg::MODE_END;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		c       = '0;
		state_n = state_q;
		mop_n   = mop_q;
		res_n   = res_q;
		c.mop   = mop_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					c.take  = 1'b1;
					state_n = S_DEC;
				end
			end
			S_DEC: begin
				if (!query) begin
					state_n = S_IDLE;
				end else if (!s.curve_ok) begin
					res_n   = kfhe_pkg::RES_ZERO;
					state_n = S_OUT;
				end else begin
					c.hdr_rd = 1'b1;
					state_n  = S_HDR;
				end
			end
			S_HDR: begin
				res_n   = kfhe_pkg::RES_ZERO;
				state_n = S_OUT;
				c.addr_sel = kfhe_pkg::ADR_ZERO;
				if (s.mode == kfhe_pkg::MODE_START) begin
					if (s.kind != kfhe_pkg::KIND_ZERO) begin
						c.key_rd = 1'b1;
						res_n    = kfhe_pkg::RES_KEY;
					end
				end else if (s.mode == kfhe_pkg::MODE_END) begin
					if (s.kind == kfhe_pkg::KIND_STATIC) begin
						c.key_rd = 1'b1;
						res_n    = kfhe_pkg::RES_KEY;
					end else if (spline) begin
						c.key_rd   = 1'b1;
						c.addr_sel = kfhe_pkg::ADR_LAST;
						res_n      = kfhe_pkg::RES_KEY;
					end
				end else begin
					if (s.kind == kfhe_pkg::KIND_STATIC) begin
						c.key_rd = 1'b1;
						res_n    = kfhe_pkg::RES_KEY;
					end else if (spline) begin
						c.srch_init = 1'b1;
						state_n     = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				if (s.len_zero) begin
					state_n = S_SCAN;
				end else begin
					c.key_rd   = 1'b1;
					c.addr_sel = kfhe_pkg::ADR_MID;
					state_n    = S_SRCH_W;
				end
			end
			S_SRCH_W: begin
				c.srch_step = 1'b1;
				state_n     = S_SRCH;
			end
			S_SCAN: begin
				c.key_rd = 1'b1;
				if (s.scan_done) begin
					// no key at or past the query: hold the last key (or key 0)
					c.addr_sel = s.k_zero ? kfhe_pkg::ADR_K : kfhe_pkg::ADR_KM1;
					res_n      = kfhe_pkg::RES_KEY;
					state_n    = S_OUT;
				end else begin
					c.addr_sel = kfhe_pkg::ADR_K;
					state_n    = S_SCAN_W;
				end
			end
			S_SCAN_W: begin
				if (!s.hit) begin
					c.scan_step = 1'b1;
					state_n     = S_SCAN;
				end else if (s.k_zero) begin
					res_n   = kfhe_pkg::RES_KEY;
					state_n = S_OUT;
				end else begin
					c.key_rd   = 1'b1;
					c.addr_sel = kfhe_pkg::ADR_KM1;
					if (s.exact) begin
						res_n   = kfhe_pkg::RES_KEY;
						state_n = S_OUT;
					end else begin
						c.keep_k = 1'b1;
						state_n  = S_PREV_W;
					end
				end
			end
			S_PREV_W: begin
				if (s.interp_ok) begin
					c.div_init = 1'b1;
					state_n    = S_DIV;
				end else begin
					res_n   = kfhe_pkg::RES_KEY;
					state_n = S_OUT;
				end
			end
			S_DIV: begin
				c.div_step = 1'b1;
				if (s.div_done) begin
					mop_n   = kfhe_pkg::OP_TT;
					state_n = S_MUL;
				end
			end
			S_MUL: begin
				c.mul_go = 1'b1;
				state_n  = S_WB;
			end
			S_WB: begin
				c.wb_go = 1'b1;
				if ((mop_q == kfhe_pkg::OP_DH && s.kind != kfhe_pkg::KIND_HERM)
					|| mop_q == kfhe_pkg::OP_DLO) begin
					res_n   = kfhe_pkg::RES_ACC;
					state_n = S_OUT;
				end else begin
					mop_n   = mop_q + 3'd1;
					state_n = S_MUL;
				end
			end
			S_OUT: begin
				// hold until the output register is free
				if (s.out_free) begin
					c.out_load = 1'b1;
					c.res_sel  = res_q;
					state_n    = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mop_q   <= kfhe_pkg::OP_TT;
			res_q   <= kfhe_pkg::RES_ZERO;
		end else begin
			state_q <= state_n;
			mop_q   <= mop_n;
			res_q   <= res_n;
		end
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		c.out_load |-> s.out_free) else $error("output word overwritten");
	a_rd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(c.key_rd && c.hdr_rd)) else $error("two table reads at once");
	a_div_seq: assert property (@(posedge clk) disable iff (!arst_n)
		c.div_init |=> state_q == S_DIV) else $error("divider not started");
	a_mul_wb: assert property (@(posedge clk) disable iff (!arst_n)
		c.mul_go |=> c.wb_go && c.mop == $past(c.mop)) else $error("product not consumed");

endmodule

@@ test/keyframe_hermite_curve_eval_unit_test.sv @@
`timescale 1ns / 1ps

module keyframe_hermite_curve_eval_unit_test;

	localparam int CURVES = kfhe_pkg::NUM_CURVES_DEF;
	localparam int KEYS = kfhe_pkg::MAX_KEYS_DEF;
	localparam int DRAIN_CYCLES = 200;
	localparam longint ONE30 = 64'sd1 << 30;

	typedef struct {
		logic [2:0]  mode;
		logic [5:0]  curve;
		logic [7:0]  slot;
		logic [2:0]  kind;
		logic [8:0]  count;
		logic [15:0] frame;
		logic [31:0] value;
		logic [31:0] tangent;
		logic [31:0] query;
		bit          known;
		logic [31:0] known_value;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] mode = kfhe_pkg::MODE_HDR;
	logic [5:0] curve_index = '0;
	logic [7:0] key_slot = '0;
	logic [2:0] curve_kind = kfhe_pkg::KIND_ZERO;
	logic [8:0] key_count = '0;
	logic [15:0] key_frame = '0;
	logic signed [31:0] key_value = '0;
	logic signed [31:0] key_tangent = '0;
	logic [31:0] query_frame = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] result_value;

	// shadow copy of the curve store
	bit floor_on;
	logic [2:0] kinds [CURVES];
	int counts [CURVES];
	logic [15:0] frames [CURVES*KEYS];
	logic [31:0] values [CURVES*KEYS];
	logic [31:0] tangents [CURVES*KEYS];
	bit written [CURVES*KEYS];

	logic [31:0] pending_values [$];
	int errors = 0;
	bit quiet = 1'b0;
	stim_row_t dir_rows [$];

	keyframe_hermite_curve_eval_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .curve_index(curve_index), .key_slot(key_slot),
		.curve_kind(curve_kind), .key_count(key_count), .key_frame(key_frame),
		.key_value(key_value), .key_tangent(key_tangent), .query_frame(query_frame),
		.out_valid(out_valid), .out_ready(out_ready), .result_value(result_value)
	);

	always #4 clk = ~clk;

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [31:0] saturate(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic longint curve_value(int c, logic [31:0] q_in);
		int b, n, lo, len, half, k;
		longint q, fi, nx, cu, df, span, t, t2, h, p1, p2, v, m1, m2, a, bb;
		bit found;
		b = c * KEYS;
		n = counts[c];
		found = 0;
		if (kinds[c] == kfhe_pkg::KIND_STATIC) return longint'(signed'(values[b]));
		if (kinds[c] != kfhe_pkg::KIND_SLOPE0 && kinds[c] != kfhe_pkg::KIND_HERM) return 0;
		q = floor_on ? longint'(q_in & 32'hFFFF_0000) : longint'(q_in);
		fi = q >> 16;
		lo = 0;
		len = n;
		while (len > 0) begin
			half = len / 2;
			if (longint'(frames[b + lo + half]) > fi) len = half;
			else begin
				lo += half + 1;
				len -= half + 1;
			end
		end
		for (k = lo; k < n; k++)
			if ((longint'(frames[b + k]) << 16) >= q) begin
				found = 1;
				break;
			end
		if (found && k > 0 && (longint'(frames[b + k]) << 16) != q) begin
			nx = longint'(frames[b + k]) << 16;
			cu = longint'(frames[b + k - 1]) << 16;
			df = q - cu;
			if (df >= 0 && nx > cu) begin
				span = longint'(frames[b + k]) - longint'(frames[b + k - 1]);
				t = (df << 14) / span;
				t2 = (t * t) >>> 30;
				h = ((3 * ONE30 - 2 * t) * t2) >>> 30;
				p1 = longint'(signed'(values[b + k - 1]));
				p2 = longint'(signed'(values[b + k]));
				v = p1 + (((p2 - p1) * h) >>> 30);
				if (kinds[c] == kfhe_pkg::KIND_HERM) begin
					m1 = longint'(signed'(tangents[b + k - 1]));
					m2 = longint'(signed'(tangents[b + k]));
					a = ((t - ONE30) * m1 + t * m2) >>> 30;
					bb = (a * (t - ONE30)) >>> 30;
					v += bb * (df >>> 16) + ((bb * (df & 64'sd65535)) >>> 16);
				end
				return v;
			end
		end
		if (k > 0) k--;
		return longint'(signed'(values[b + k]));
	endfunction

	// apply one accepted word to the shadow store, queue its result if any
	function automatic void absorb_word(stim_row_t r);
		int b, n;
		logic [31:0] res;
		b = int'(r.curve) * KEYS;
		n = counts[r.curve];
		case (r.mode)
			kfhe_pkg::MODE_HDR: begin
				kinds[r.curve] = r.kind;
				counts[r.curve] = (r.count > KEYS) ? KEYS : int'(r.count);
			end
			kfhe_pkg::MODE_KEY: begin
				frames[b + r.slot] = r.frame;
				values[b + r.slot] = r.value;
				tangents[b + r.slot] = r.tangent;
				written[b + r.slot] = 1;
			end
			kfhe_pkg::MODE_EVAL, kfhe_pkg::MODE_START, kfhe_pkg::MODE_END: begin
				if (r.mode == kfhe_pkg::MODE_EVAL)
					res = saturate(curve_value(r.curve, r.query));
				else if (r.mode == kfhe_pkg::MODE_START)
					res = (kinds[r.curve] != kfhe_pkg::KIND_ZERO) ? values[b] : '0;
				else if (kinds[r.curve] == kfhe_pkg::KIND_STATIC) res = values[b];
				else if (kinds[r.curve] == kfhe_pkg::KIND_SLOPE0
					|| kinds[r.curve] == kfhe_pkg::KIND_HERM)
					res = values[b + (n > 0 ? n - 1 : 0)];
				else res = '0;
				pending_values.push_back(r.known ? r.known_value : res);
			end
			default: ;
		endcase
	endfunction

	function automatic bit curve_ready(int c);
		int need;
		need = (counts[c] > 0) ? counts[c] : 1;
		for (int i = 0; i < need; i++)
			if (!written[c * KEYS + i]) return 0;
		return 1;
	endfunction

	function automatic stim_row_t row(logic [2:0] m, int c, int s, logic [2:0] kd, int cnt,
			int fr, logic [31:0] val, logic [31:0] tan, logic [31:0] q,
			bit known = 0, logic [31:0] kv = '0);
		stim_row_t r;
		r.mode = m; r.curve = 6'(c); r.slot = 8'(s); r.kind = kd; r.count = 9'(cnt);
		r.frame = 16'(fr); r.value = val; r.tangent = tan; r.query = q;
		r.known = known; r.known_value = kv;
		return r;
	endfunction

	task automatic send_word(stim_row_t r);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= r.mode;
		curve_index <= r.curve;
		key_slot <= r.slot;
		curve_kind <= r.kind;
		key_count <= r.count;
		key_frame <= r.frame;
		key_value <= r.value;
		key_tangent <= r.tangent;
		query_frame <= r.query;
		do @(posedge clk); while (!in_ready);
		absorb_word(r);
	endtask

	task automatic write_floor(bit v);
		// drop the last word so it is not taken again while draining
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		floor_on = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// output side: random stall bursts, none once quiet
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 16);
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_values.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, result_value);
				errors++;
			end else begin
				want = pending_values.pop_front();
				if (result_value !== want) begin
					$display("%0t: result_value mismatch: expected %h, actual %h",
						$time, want, result_value);
					errors++;
				end
			end
		end
	end

	initial begin
		int sent, c, n, kd, fr, lo_fr, nq, pick;
		bit big_done;
		stim_row_t r;
		floor_on = 0;
		big_done = 0;
		for (int i = 0; i < CURVES; i++) begin
			kinds[i] = kfhe_pkg::KIND_ZERO;
			counts[i] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_floor(0);

		// fresh state, static, extremes, held ends, empty curve, keys out of order
		dir_rows.push_back(row(kfhe_pkg::MODE_EVAL, 5, 0, kfhe_pkg::KIND_ZERO, 0, 0, 0, 0,
			32'h0003_8000, 1, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_START, 5, 0, kfhe_pkg::KIND_ZERO, 0, 0, 0, 0, 0,
			1, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_END, 5, 0, kfhe_pkg::KIND_ZERO, 0, 0, 0, 0, 0,
			1, 0));
		dir_rows.push_back(row(3'd5, 5, 0, kfhe_pkg::KIND_HERM, 9, 1, 1, 1, 1));
		dir_rows.push_back(row(kfhe_pkg::MODE_HDR, 1, 0, kfhe_pkg::KIND_STATIC, 1, 0, 0, 0, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_KEY, 1, 0, 0, 0, 7, 32'h7FFF_FFFF, 0, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_EVAL, 1, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF,
			1, 32'h7FFF_FFFF));
		dir_rows.push_back(row(kfhe_pkg::MODE_END, 1, 0, 0, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF));
		dir_rows.push_back(row(kfhe_pkg::MODE_HDR, 2, 0, kfhe_pkg::KIND_HERM, 2, 0, 0, 0, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_KEY, 2, 0, 0, 0, 0, 32'h8000_0000,
			32'h7FFF_FFFF, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_KEY, 2, 1, 0, 0, 65535, 32'h7FFF_FFFF,
			32'h8000_0000, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_EVAL, 2, 0, 0, 0, 0, 0, 0, 0, 1, 32'h8000_0000));
		dir_rows.push_back(row(kfhe_pkg::MODE_EVAL, 2, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF,
			1, 32'h7FFF_FFFF));
		dir_rows.push_back(row(kfhe_pkg::MODE_EVAL, 2, 0, 0, 0, 0, 0, 0, 32'h1234_5678));
		dir_rows.push_back(row(kfhe_pkg::MODE_EVAL, 2, 0, 0, 0, 0, 0, 0, 32'hC000_0001));
		dir_rows.push_back(row(kfhe_pkg::MODE_START, 2, 0, 0, 0, 0, 0, 0, 0, 1, 32'h8000_0000));
		dir_rows.push_back(row(kfhe_pkg::MODE_HDR, 3, 0, kfhe_pkg::KIND_SLOPE0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_KEY, 3, 0, 0, 0, 4, 32'd5, 0, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_EVAL, 3, 0, 0, 0, 0, 0, 0, 32'h0009_0000,
			1, 32'd5));
		dir_rows.push_back(row(kfhe_pkg::MODE_END, 3, 0, 0, 0, 0, 0, 0, 0, 1, 32'd5));
		dir_rows.push_back(row(kfhe_pkg::MODE_HDR, 4, 0, kfhe_pkg::KIND_SLOPE0, 2, 0, 0, 0, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_KEY, 4, 0, 0, 0, 100, 32'h0001_0000, 0, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_KEY, 4, 1, 0, 0, 50, 32'hFFFF_0000, 0, 0));
		dir_rows.push_back(row(kfhe_pkg::MODE_EVAL, 4, 0, 0, 0, 0, 0, 0, 32'h004B_0000));
		dir_rows.push_back(row(kfhe_pkg::MODE_EVAL, 4, 0, 0, 0, 0, 0, 0, 32'h0064_0000));
		foreach (dir_rows[i]) send_word(dir_rows[i]);

		sent = 0;
		for (int phase = 0; phase < 5; phase++) begin
			write_floor(1'(phase % 2));
			while (sent < (phase + 1) * 190) begin
				if (sent > 850) quiet = 1;
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					// ignored mode, or a stray query on any usable curve
					r = row(3'($urandom_range(5, 7)), $urandom, $urandom, 3'($urandom),
						$urandom, $urandom, $urandom, $urandom, $urandom);
					c = $urandom_range(0, CURVES - 1);
					if ($urandom_range(0, 1) && curve_ready(c)) begin
						r.mode = 3'($urandom_range(kfhe_pkg::MODE_EVAL, kfhe_pkg::MODE_END));
						r.curve = 6'(c);
						sent++;
					end
					send_word(r);
					continue;
				end
				c = $urandom_range(0, CURVES - 1);
				kd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 3);
				n = $urandom_range(0, 6);
				if (!big_done && phase == 1) begin
					n = $urandom_range(257, 511);
					big_done = 1;
				end
				send_word(row(kfhe_pkg::MODE_HDR, c, 0, 3'(kd), n, 0, 0, 0, 0));
				sent++;
				if (n > KEYS) n = KEYS;
				lo_fr = $urandom_range(0, 16000);
				fr = lo_fr;
				for (int k = 0; k < ((n > 0) ? n : 1); k++) begin
					if (n == KEYS) fr = k * 257;
					else if ($urandom_range(0, 9) == 0) fr = $urandom_range(0, 65535);
					else if (k > 0)
						fr = fr + (($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8000));
					if (fr > 65535) fr = 65535;
					send_word(row(kfhe_pkg::MODE_KEY, c, k, 0, 0, fr,
						$urandom_range(0, 2) ? $urandom : $urandom_range(0, 32'h3_0000) - 32'h1_8000,
						$urandom_range(0, 2) ? $urandom : $urandom_range(0, 32'h4_0000) - 32'h2_0000,
						0));
					sent++;
				end
				nq = $urandom_range(2, 6);
				for (int i = 0; i < nq; i++) begin
					r = row(kfhe_pkg::MODE_EVAL, c, 0, 0, 0, 0, 0, 0, 0);
					pick = $urandom_range(0, 9);
					if (pick == 0) r.mode = kfhe_pkg::MODE_START;
					else if (pick == 1) r.mode = kfhe_pkg::MODE_END;
					pick = $urandom_range(0, 9);
					if (pick < 2) r.query = $urandom;
					else if (pick < 4) r.query = 32'(frames[c * KEYS + $urandom_range(0,
						(n > 0) ? n - 1 : 0)]) << 16;
					else r.query = (32'($urandom_range(lo_fr > 2 ? lo_fr - 2 : 0, fr + 2)) << 16)
						| 32'($urandom_range(0, 65535));
					send_word(r);
					sent++;
				end
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

@@ keyframe_hermite_curve_eval_unit.f @@
hdl/kfhe_pkg.sv
hdl/kfhe_ram.sv
hdl/kfhe_dp.sv
hdl/kfhe_ctrl.sv
hdl/keyframe_hermite_curve_eval_unit.sv
test/keyframe_hermite_curve_eval_unit_test.sv
